/* hdl/assert_macros.svh */
// Assertion macros for the RTL files that check themselves.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dqpi_pkg.sv */
// Package for the dq current PI controller: microcode types, the control store,
// register map and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package dqpi_pkg;

	// Register map
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_VOLTAGE_SQ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_TIME_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 3'd5;

	typedef struct packed {
		logic [30:0] prop_gain;
		logic [30:0] integral_gain;
		logic [30:0] sat_voltage_sq;
		logic [30:0] max_current;
		logic [31:0] sat_time_limit;
		logic [31:0] tick_period;
	} cfg_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP      = 4'd0,
		OP_ERR      = 4'd1,
		OP_PCLAMP   = 4'd2,
		OP_INC      = 4'd3,
		OP_ACC      = 4'd4,
		OP_CLIP_HI  = 4'd5,
		OP_CLIP_LO  = 4'd6,
		OP_OUT      = 4'd7,
		OP_SQ_FIRST = 4'd8,
		OP_SQ_ADD   = 4'd9,
		OP_TMR_UP   = 4'd10,
		OP_TMR_DN   = 4'd11,
		OP_FAULT    = 4'd12
	} op_t;

	// Multiplier operand selection
	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_KP   = 3'd1,
		MUL_KI   = 3'd2,
		MUL_UD   = 3'd3,
		MUL_UQ   = 3'd4
	} mul_t;

	// Jump conditions
	typedef enum logic [1:0] {
		JC_NONE    = 2'd0,
		JC_ALWAYS  = 2'd1,
		JC_ERR_NEG = 2'd2,
		JC_NOT_SAT = 2'd3
	} jc_t;

	localparam int STEP_W = 5;

	// Jump targets in the control store
	localparam logic [STEP_W-1:0] ST_D_CLIP_LO = 5'd6;
	localparam logic [STEP_W-1:0] ST_D_OUT     = 5'd7;
	localparam logic [STEP_W-1:0] ST_Q_CLIP_LO = 5'd14;
	localparam logic [STEP_W-1:0] ST_Q_OUT     = 5'd15;
	localparam logic [STEP_W-1:0] ST_TMR_DN    = 5'd21;
	localparam logic [STEP_W-1:0] ST_FAULT     = 5'd22;

	// Axis select
	localparam logic AX_D = 1'b0;
	localparam logic AX_Q = 1'b1;

	typedef struct packed {
		op_t               op;
		logic              ax;
		mul_t              mul;
		jc_t               jc;
		logic [STEP_W-1:0] tgt;
		logic              last;
	} ctrl_t;

	// Status flags fed back to the sequencer
	typedef struct packed {
		logic err_neg;
		logic not_sat;
	} flags_t;

	localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
	localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
		logic signed [31:0] r;
		if (x > SAT_HI) r = 32'sh7FFF_FFFF;
		else if (x < SAT_LO) r = 32'sh8000_0000;
		else r = x[31:0];
		return r;
	endfunction

	function automatic ctrl_t cw(input op_t op, input logic ax, input mul_t mul,
			input jc_t jc, input logic [STEP_W-1:0] tgt, input logic last);
		ctrl_t c;
		c.op   = op;
		c.ax   = ax;
		c.mul  = mul;
		c.jc   = jc;
		c.tgt  = tgt;
		c.last = last;
		return c;
	endfunction

	// Control store: one control word per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		case (step)
			// d axis
			5'd0:  c = cw(OP_ERR,      AX_D, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd1:  c = cw(OP_NOP,      AX_D, MUL_KP,   JC_NONE,    '0, 1'b0);
			5'd2:  c = cw(OP_PCLAMP,   AX_D, MUL_KI,   JC_NONE,    '0, 1'b0);
			5'd3:  c = cw(OP_INC,      AX_D, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd4:  c = cw(OP_ACC,      AX_D, MUL_NONE, JC_ERR_NEG, ST_D_CLIP_LO, 1'b0);
			5'd5:  c = cw(OP_CLIP_HI,  AX_D, MUL_NONE, JC_ALWAYS,  ST_D_OUT, 1'b0);
			5'd6:  c = cw(OP_CLIP_LO,  AX_D, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd7:  c = cw(OP_OUT,      AX_D, MUL_NONE, JC_NONE,    '0, 1'b0);
			// q axis
			5'd8:  c = cw(OP_ERR,      AX_Q, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd9:  c = cw(OP_NOP,      AX_Q, MUL_KP,   JC_NONE,    '0, 1'b0);
			5'd10: c = cw(OP_PCLAMP,   AX_Q, MUL_KI,   JC_NONE,    '0, 1'b0);
			5'd11: c = cw(OP_INC,      AX_Q, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd12: c = cw(OP_ACC,      AX_Q, MUL_NONE, JC_ERR_NEG, ST_Q_CLIP_LO, 1'b0);
			5'd13: c = cw(OP_CLIP_HI,  AX_Q, MUL_NONE, JC_ALWAYS,  ST_Q_OUT, 1'b0);
			5'd14: c = cw(OP_CLIP_LO,  AX_Q, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd15: c = cw(OP_OUT,      AX_Q, MUL_NONE, JC_NONE,    '0, 1'b0);
			// magnitude check and watchdog
			5'd16: c = cw(OP_NOP,      AX_D, MUL_UD,   JC_NONE,    '0, 1'b0);
			5'd17: c = cw(OP_SQ_FIRST, AX_D, MUL_UQ,   JC_NONE,    '0, 1'b0);
			5'd18: c = cw(OP_SQ_ADD,   AX_D, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd19: c = cw(OP_NOP,      AX_D, MUL_NONE, JC_NOT_SAT, ST_TMR_DN, 1'b0);
			5'd20: c = cw(OP_TMR_UP,   AX_D, MUL_NONE, JC_ALWAYS,  ST_FAULT, 1'b0);
			5'd21: c = cw(OP_TMR_DN,   AX_D, MUL_NONE, JC_NONE,    '0, 1'b0);
			5'd22: c = cw(OP_FAULT,    AX_D, MUL_NONE, JC_NONE,    '0, 1'b1);
			default: c = cw(OP_NOP,    AX_D, MUL_NONE, JC_NONE,    '0, 1'b1);
		endcase
		return c;
	endfunction

endpackage

/* hdl/dqpi_cfg_regs.sv */
// Configuration register file of the dq current PI controller.
// Depends on dqpi_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps

module dqpi_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [dqpi_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [31:0]                      wr_data,
	output dqpi_pkg::cfg_t                   cfg
);

	dqpi_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= '0;
			cfg_q.integral_gain  <= '0;
			cfg_q.sat_voltage_sq <= 31'h7FFF_FFFF;
			cfg_q.max_current    <= 31'h7FFF_FFFF;
			cfg_q.sat_time_limit <= 32'hFFFF_FFFF;
			cfg_q.tick_period    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				dqpi_pkg::REG_PROP_GAIN:      cfg_q.prop_gain      <= wr_data[30:0];
				dqpi_pkg::REG_INTEGRAL_GAIN:  cfg_q.integral_gain  <= wr_data[30:0];
				dqpi_pkg::REG_SAT_VOLTAGE_SQ: cfg_q.sat_voltage_sq <= wr_data[30:0];
				dqpi_pkg::REG_MAX_CURRENT:    cfg_q.max_current    <= wr_data[30:0];
				dqpi_pkg::REG_SAT_TIME_LIMIT: cfg_q.sat_time_limit <= wr_data;
				dqpi_pkg::REG_TICK_PERIOD:    cfg_q.tick_period    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/dqpi_sequencer.sv */
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on dqpi_pkg for the control word, flags and the ucode table.
`timescale 1ns / 1ps

module dqpi_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  hold,
	input  dqpi_pkg::flags_t      flags,
	output dqpi_pkg::ctrl_t       ctrl,
	output logic                  busy,
	output logic                  step_en
);

	logic [dqpi_pkg::STEP_W-1:0] step_q;
	logic                        run_q;
	logic                        take_jump;

	assign ctrl    = dqpi_pkg::ucode(step_q);
	assign busy    = run_q;
	assign step_en = run_q && !hold;

	// Jump condition decode
	always_comb begin
		case (ctrl.jc)
			dqpi_pkg::JC_NONE:    take_jump = 1'b0;
			dqpi_pkg::JC_ALWAYS:  take_jump = 1'b1;
			dqpi_pkg::JC_ERR_NEG: take_jump = flags.err_neg;
			dqpi_pkg::JC_NOT_SAT: take_jump = flags.not_sat;
			default:              take_jump = 1'b0;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
		end else if (start) begin
			step_q <= '0;
			run_q  <= 1'b1;
		end else if (step_en) begin
			if (ctrl.last) begin
				run_q  <= 1'b0;
				step_q <= '0;
			end else if (take_jump) begin
				step_q <= ctrl.tgt;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

/* hdl/dqpi_datapath.sv */
// Datapath of the dq current PI controller: shared multiplier, saturating ALU,
// integrators, watchdog timer and fault flag. Depends on dqpi_pkg.
`timescale 1ns / 1ps

module dqpi_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic signed [31:0]  d_cmd,
	input  logic signed [31:0]  q_cmd,
	input  logic signed [31:0]  d_meas,
	input  logic signed [31:0]  q_meas,
	input  logic [30:0]         supply_voltage,
	input  logic                en,
	input  dqpi_pkg::ctrl_t     ctrl,
	input  dqpi_pkg::cfg_t      cfg,
	output dqpi_pkg::flags_t    flags,
	output logic signed [31:0]  ud,
	output logic signed [31:0]  uq,
	output logic [31:0]         timer,
	output logic                fault_nxt
);

	// Latched item
	logic signed [31:0] d_cmd_q, q_cmd_q, d_meas_q, q_meas_q;
	logic [30:0]        ubus_q;

	// Working registers
	logic signed [31:0] err_q, p_q, inc_q, acc_q, sq_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] d_integ_q, q_integ_q, ud_q, uq_q;
	logic [31:0]        timer_q;
	logic               fault_q;

	// Combinational views
	logic signed [31:0] mul_a, mul_b;
	logic signed [31:0] cmd_sel, meas_sel, integ_sel;
	logic signed [48:0] ubus49, lim49, cmd49, cmd_clamp;
	logic signed [48:0] prod_sh, p_clamp;
	logic signed [63:0] prod_rnd;
	logic signed [31:0] err_nxt, inc_nxt, acc_nxt, hi_bnd, lo_bnd, u_nxt, sq1, sq_sum;
	logic [32:0]        tmr_sum;
	logic [31:0]        tmr_up, tmr_dn;

	// Item capture on an enabled transfer
	always_ff @(posedge clk) begin
		if (load) begin
			d_cmd_q  <= d_cmd;
			q_cmd_q  <= q_cmd;
			d_meas_q <= d_meas;
			q_meas_q <= q_meas;
			ubus_q   <= supply_voltage;
		end
	end

	// Axis selection
	assign cmd_sel   = (ctrl.ax == dqpi_pkg::AX_Q) ? q_cmd_q : d_cmd_q;
	assign meas_sel  = (ctrl.ax == dqpi_pkg::AX_Q) ? q_meas_q : d_meas_q;
	assign integ_sel = (ctrl.ax == dqpi_pkg::AX_Q) ? q_integ_q : d_integ_q;

	// Multiplier operands
	always_comb begin
		case (ctrl.mul)
			dqpi_pkg::MUL_KP: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, cfg.prop_gain});
			end
			dqpi_pkg::MUL_KI: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, cfg.integral_gain});
			end
			dqpi_pkg::MUL_UD: begin
				mul_a = ud_q;
				mul_b = ud_q;
			end
			dqpi_pkg::MUL_UQ: begin
				mul_a = uq_q;
				mul_b = uq_q;
			end
			default: begin
				mul_a = err_q;
				mul_b = err_q;
			end
		endcase
	end

	// Shared 32x32 multiplier, registered
	always_ff @(posedge clk) begin
		if (en && ctrl.mul != dqpi_pkg::MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Error: clamp the command, subtract feedback
	assign ubus49 = $signed({18'd0, ubus_q});
	assign lim49  = $signed({18'd0, cfg.max_current});
	assign cmd49  = 49'(cmd_sel);
	always_comb begin
		if (cmd49 > lim49) cmd_clamp = lim49;
		else if (cmd49 < -lim49) cmd_clamp = -lim49;
		else cmd_clamp = cmd49;
	end
	assign err_nxt = dqpi_pkg::sat32(cmd_clamp - 49'(meas_sel));

	// Proportional term: floor shift, clamp to the bus voltage
	assign prod_sh = $signed(prod_q[63:15]);
	always_comb begin
		if (prod_sh > ubus49) p_clamp = ubus49;
		else if (prod_sh < -ubus49) p_clamp = -ubus49;
		else p_clamp = prod_sh;
	end

	// Integral increment, rounded half up
	assign prod_rnd = prod_q + 64'sd16384;
	assign inc_nxt  = dqpi_pkg::sat32($signed(prod_rnd[63:15]));

	// Integrator, anti-windup bounds, axis output
	assign acc_nxt = dqpi_pkg::sat32(49'(integ_sel) + 49'(inc_q));
	assign hi_bnd  = dqpi_pkg::sat32(ubus49 - 49'(p_q));
	assign lo_bnd  = dqpi_pkg::sat32(-ubus49 - 49'(p_q));
	assign u_nxt   = dqpi_pkg::sat32(49'(p_q) + 49'(acc_q));

	// Squared magnitude
	assign sq1    = dqpi_pkg::sat32(prod_sh);
	assign sq_sum = dqpi_pkg::sat32(49'(sq_q) + 49'(sq1));

	// Watchdog timer steps
	assign tmr_sum = {1'b0, timer_q} + {1'b0, cfg.tick_period};
	assign tmr_up  = tmr_sum[32] ? 32'hFFFF_FFFF : tmr_sum[31:0];
	assign tmr_dn  = (timer_q > cfg.tick_period) ? (timer_q - cfg.tick_period) : 32'd0;

	// Working registers without reset
	always_ff @(posedge clk) begin
		if (en) begin
			case (ctrl.op)
				dqpi_pkg::OP_ERR:      err_q <= err_nxt;
				dqpi_pkg::OP_PCLAMP:   p_q   <= p_clamp[31:0];
				dqpi_pkg::OP_INC:      inc_q <= inc_nxt;
				dqpi_pkg::OP_ACC:      acc_q <= acc_nxt;
				dqpi_pkg::OP_CLIP_HI:  if (acc_q > hi_bnd) acc_q <= hi_bnd;
				dqpi_pkg::OP_CLIP_LO:  if (acc_q < lo_bnd) acc_q <= lo_bnd;
				dqpi_pkg::OP_OUT: begin
					if (ctrl.ax == dqpi_pkg::AX_Q) uq_q <= u_nxt;
					else ud_q <= u_nxt;
				end
				dqpi_pkg::OP_SQ_FIRST: sq_q <= sq1;
				dqpi_pkg::OP_SQ_ADD:   sq_q <= sq_sum;
				default: ;
			endcase
		end
	end

	// Controller state: integrators, timer, fault
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_integ_q <= '0;
			q_integ_q <= '0;
			timer_q   <= '0;
			fault_q   <= 1'b0;
		end else if (en) begin
			case (ctrl.op)
				dqpi_pkg::OP_OUT: begin
					if (ctrl.ax == dqpi_pkg::AX_Q) q_integ_q <= acc_q;
					else d_integ_q <= acc_q;
				end
				dqpi_pkg::OP_TMR_UP: timer_q <= tmr_up;
				dqpi_pkg::OP_TMR_DN: timer_q <= tmr_dn;
				dqpi_pkg::OP_FAULT:  fault_q <= fault_nxt;
				default: ;
			endcase
		end
	end

	assign flags.err_neg = err_q[31];
	assign flags.not_sat = !(sq_q > $signed({1'b0, cfg.sat_voltage_sq}));

	assign ud        = ud_q;
	assign uq        = uq_q;
	assign timer     = timer_q;
	assign fault_nxt = fault_q || (timer_q > cfg.sat_time_limit);

endmodule

/* hdl/dq_current_pi_controller.sv */
// dq current PI controller with anti-windup clamp and saturation watchdog. A tick
// with enable high starts the microprogram, whose 20 executed steps run all
// arithmetic through one shared 32x32 multiplier and one saturating ALU; the
// input stalls while it runs and the next tick is taken once the sequencer is idle.
// A tick with enable low does not start the sequencer and gives no result.
// A finished result waits in the output register while the next tick runs; the
// sequencer holds on its last step if the register is still full and the receiver stalls.
// Depends on dqpi_pkg, dqpi_cfg_regs, dqpi_sequencer, dqpi_datapath, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dq_current_pi_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dqpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           enable,
	input  logic signed [31:0]             d_cmd,
	input  logic signed [31:0]             q_cmd,
	input  logic signed [31:0]             d_meas,
	input  logic signed [31:0]             q_meas,
	input  logic [30:0]                    supply_voltage,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             d_volt,
	output logic signed [31:0]             q_volt,
	output logic                           fault,
	output logic [31:0]                    sat_timer_out
);

	dqpi_pkg::cfg_t   cfg;
	dqpi_pkg::ctrl_t  ctrl;
	dqpi_pkg::flags_t flags;
	logic             busy, step_en, hold, in_xfer, start;
	logic             out_valid_q, res_load;
	logic signed [31:0] ud, uq;
	logic [31:0]      timer;
	logic             fault_nxt;
	logic             u_dp_fault_seen;

	assign cfg_ready = 1'b1;

	// Input handshake
	assign in_stall = busy;
	assign in_xfer  = in_valid && !in_stall;
	assign start    = in_xfer && enable;

	// Last step waits while the previous result is still held
	assign hold     = ctrl.last && out_valid_q && out_stall;
	assign res_load = step_en && ctrl.last;

	dqpi_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dqpi_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.hold    (hold),
		.flags   (flags),
		.ctrl    (ctrl),
		.busy    (busy),
		.step_en (step_en)
	);

	dqpi_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (start),
		.d_cmd          (d_cmd),
		.q_cmd          (q_cmd),
		.d_meas         (d_meas),
		.q_meas         (q_meas),
		.supply_voltage (supply_voltage),
		.en             (step_en),
		.ctrl           (ctrl),
		.cfg            (cfg),
		.flags          (flags),
		.ud             (ud),
		.uq             (uq),
		.timer          (timer),
		.fault_nxt      (fault_nxt)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			d_volt        <= ud;
			q_volt        <= uq;
			fault         <= fault_nxt;
			sat_timer_out <= timer;
		end
	end

	assign out_valid = out_valid_q;

	assign u_dp_fault_seen = fault_nxt && step_en && ctrl.op == dqpi_pkg::OP_FAULT;

	// Checks
	`ASSERT_NEXT(a_start_busy, start, busy, "sequencer did not start on a ticked transfer")
	`ASSERT_NEXT(a_idle_skip, in_xfer && !enable, !busy, "disabled tick started the sequencer")
	`ASSERT_IMPLY(a_load_busy, $rose(out_valid_q), $past(busy), "result loaded while idle")
	`ASSERT_NEXT(a_fault_sticky, u_dp_fault_seen, fault_nxt, "fault flag cleared outside reset")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for dq_current_pi_controller: control ticks go in over the stall
// handshake and each voltage command is checked against a behavioral PI loop model.
// Depends on dqpi_pkg and the controller RTL.

module tb_top;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 30;
	localparam int RAND_PHASES     = 8;
	localparam int TICKS_PER_PHASE = 50;
	localparam int AMP             = 32768;   // 1.0 in s16.15

	// indexes past the register map, writes must be ignored
	localparam logic [dqpi_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [dqpi_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint U32_MAX = 64'sd4294967295;

	localparam logic signed [31:0] I_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] I_MIN   = 32'sh8000_0000;
	localparam logic [30:0]        V_MAX   = 31'h7FFF_FFFF;
	localparam logic [30:0]        BUS_48V = 31'd1572864;

	typedef struct packed {
		logic               en;
		logic signed [31:0] dc;
		logic signed [31:0] qc;
		logic signed [31:0] dm;
		logic signed [31:0] qm;
		logic [30:0]        vbus;
		logic               drain;   // hold off until every pending result is out
	} tick_t;

	typedef struct packed {
		logic signed [31:0] ud;
		logic signed [31:0] uq;
		logic               flt;
		logic [31:0]        tmr;
	} volt_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_DITHER,
		STALL_SOLID
	} stall_mode_t;

	logic                           clk            = 1'b0;
	logic                           arst_n         = 1'b0;
	logic                           cfg_valid      = 1'b0;
	logic                           cfg_ready;
	logic [dqpi_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
	logic [31:0]                    cfg_data       = '0;
	logic                           in_valid       = 1'b0;
	logic                           in_stall;
	logic                           enable         = 1'b0;
	logic signed [31:0]             d_cmd          = '0;
	logic signed [31:0]             q_cmd          = '0;
	logic signed [31:0]             d_meas         = '0;
	logic signed [31:0]             q_meas         = '0;
	logic [30:0]                    supply_voltage = '0;
	logic                           out_valid;
	logic                           out_stall      = 1'b0;
	logic signed [31:0]             d_volt;
	logic signed [31:0]             q_volt;
	logic                           fault;
	logic [31:0]                    sat_timer_out;

	// Controller model: configuration copy and loop state
	longint kp_gain      = 0;
	longint ki_gain      = 0;
	longint volt_sq_lim  = S32_MAX;
	longint cur_lim      = S32_MAX;
	longint flt_time_lim = U32_MAX;
	longint tmr_step     = 0;
	longint integ[2]     = '{0, 0};
	longint tmr          = 0;
	logic   flt          = 1'b0;

	tick_t       tick_q[$];
	volt_t       pending_volts[$];
	tick_t       cur_tick;
	volt_t       want;
	int          burst_left   = 1;
	int          gap_left     = 0;
	logic        present;
	stall_mode_t seg_mode     = STALL_NONE;
	int          seg_left     = 0;
	int          n_errors     = 0;
	int          quiet_cycles = 0;

	dq_current_pi_controller u_top (.*);

	initial forever #5 clk = ~clk;

	function automatic longint clip32(input longint x);
		if (x > S32_MAX) return S32_MAX;
		if (x < S32_MIN) return S32_MIN;
		return x;
	endfunction

	function automatic longint clip_sym(input longint x, input longint lim);
		if (x > lim) return lim;
		if (x < -lim) return -lim;
		return x;
	endfunction

	// One axis of the PI loop; anti-windup clamp follows the error sign
	function automatic longint axis_volt(input int ax, input longint cmd, input longint meas,
			input longint vbus);
		longint err, p, inc, acc;
		err = clip32(clip_sym(cmd, cur_lim) - meas);
		p   = clip_sym((err * kp_gain) >>> 15, vbus);
		inc = clip32((err * ki_gain + 64'sd16384) >>> 15);
		acc = clip32(integ[ax] + inc);
		if (err >= 0) begin
			if (acc > clip32(vbus - p)) acc = clip32(vbus - p);
		end else begin
			if (acc < clip32(-vbus - p)) acc = clip32(-vbus - p);
		end
		integ[ax] = acc;
		return clip32(p + acc);
	endfunction

	// Full enabled tick: both axes, magnitude check, saturation timer, sticky fault
	function automatic volt_t pi_tick(input tick_t t);
		volt_t  r;
		longint ud, uq, mag;
		ud  = axis_volt(0, longint'($signed(t.dc)), longint'($signed(t.dm)), longint'(t.vbus));
		uq  = axis_volt(1, longint'($signed(t.qc)), longint'($signed(t.qm)), longint'(t.vbus));
		mag = clip32(clip32((ud * ud) >>> 15) + clip32((uq * uq) >>> 15));
		if (mag > volt_sq_lim)
			tmr = (tmr + tmr_step > U32_MAX) ? U32_MAX : tmr + tmr_step;
		else
			tmr = (tmr > tmr_step) ? tmr - tmr_step : 0;
		if (tmr > flt_time_lim) flt = 1'b1;
		r.ud  = ud[31:0];
		r.uq  = uq[31:0];
		r.flt = flt;
		r.tmr = tmr[31:0];
		return r;
	endfunction

	function automatic void add_tick(input logic en, input logic signed [31:0] dc, qc, dm, qm,
			input logic [30:0] vbus, input logic drain);
		tick_t t;
		t = '{en, dc, qc, dm, qm, vbus, drain};
		tick_q.push_back(t);
	endfunction

	// Current within +/-range amps, random fraction
	function automatic logic signed [31:0] rand_amps(input int range);
		return $signed($urandom_range(0, 2 * range * AMP)) - range * AMP;
	endfunction

	function automatic logic signed [31:0] corner_val();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return I_MAX;
			2: return I_MIN;
			3: return 32'sd1;
			default: return -32'sd1;
		endcase
	endfunction

	// Register value: zero, top (bit 31 random), typical range or anything
	function automatic logic [31:0] pick_reg_value(input logic [31:0] typical_hi,
			input logic [31:0] top);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return top | (32'($urandom_range(0, 1)) << 31);
			2, 3: return $urandom_range(0, typical_hi);
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (n_errors < 100)
			$display("%0t  mismatch %s: got %h, expected %h", $time, what, got, exp_val);
		n_errors++;
	endtask

	// Config transfer, then update the model copy
	task automatic write_reg(input logic [dqpi_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			dqpi_pkg::REG_PROP_GAIN:      kp_gain      = longint'(val[30:0]);
			dqpi_pkg::REG_INTEGRAL_GAIN:  ki_gain      = longint'(val[30:0]);
			dqpi_pkg::REG_SAT_VOLTAGE_SQ: volt_sq_lim  = longint'(val[30:0]);
			dqpi_pkg::REG_MAX_CURRENT:    cur_lim      = longint'(val[30:0]);
			dqpi_pkg::REG_SAT_TIME_LIMIT: flt_time_lim = longint'(val);
			dqpi_pkg::REG_TICK_PERIOD:    tmr_step     = longint'(val);
			default: ;
		endcase
	endtask

	// Wait until the block is drained, then let a disabled tick finish too
	task automatic settle();
		@(negedge clk);
		while (tick_q.size() != 0 || in_valid || pending_volts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: bursts of transfers with random gaps in between
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			present = 1'b0;
			if (in_valid && !in_stall) begin
				if (cur_tick.en) pending_volts.push_back(pi_tick(cur_tick));
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					case ($urandom_range(0, 4))
						0, 1: gap_left = 0;
						2, 3: gap_left = $urandom_range(1, 5);
						default: gap_left = $urandom_range(6, 30);
					endcase
				end
				present = (gap_left == 0);
			end else if (!in_valid) begin
				if (gap_left > 0) gap_left--;
				else present = 1'b1;
			end
			if (present && tick_q.size() != 0 &&
					!(tick_q[0].drain && pending_volts.size() != 0)) begin
				cur_tick       = tick_q.pop_front();
				in_valid       <= 1'b1;
				enable         <= cur_tick.en;
				d_cmd          <= cur_tick.dc;
				q_cmd          <= cur_tick.qc;
				d_meas         <= cur_tick.dm;
				q_meas         <= cur_tick.qm;
				supply_voltage <= cur_tick.vbus;
			end else if (!(in_valid && in_stall)) begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: free, dithered and solid stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			seg_left  = 0;
		end else begin
			if (seg_left == 0) begin
				seg_mode = stall_mode_t'($urandom_range(0, 2));
				seg_left = (seg_mode == STALL_SOLID) ? $urandom_range(1, 40)
					: $urandom_range(10, 60);
			end
			seg_left--;
			case (seg_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_DITHER: out_stall <= 1'($urandom_range(0, 1));
				default:      out_stall <= 1'b1;
			endcase
		end
	end

	// Monitor: each output transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_volts.size() == 0) begin
				report_mismatch("result with nothing pending", '0, '0);
			end else begin
				want = pending_volts.pop_front();
				if (d_volt !== want.ud) report_mismatch("d_volt", d_volt, want.ud);
				if (q_volt !== want.uq) report_mismatch("q_volt", q_volt, want.uq);
				if (fault !== want.flt) report_mismatch("fault", 32'(fault), 32'(want.flt));
				if (sat_timer_out !== want.tmr)
					report_mismatch("sat_timer_out", sat_timer_out, want.tmr);
			end
		end
	end

	// Watchdog: too long without any transfer on any channel
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Stimulus: reset defaults, directed ticks, then random phases
	initial begin
		logic signed [31:0] dc, qc, dm, qm, set_d, set_q;
		logic [30:0]        vbus;
		logic               en;
		int                 n_en, roll;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// register reset values: zero gains give zero output
		for (int i = 0; i < 5; i++)
			add_tick(1'b1, rand_amps(60), rand_amps(60), rand_amps(60), rand_amps(60),
				BUS_48V, 1'b0);
		settle();

		// directed: unit kp, ki 0.125, 10 V magnitude limit, 30 A clamp, half-period step
		write_reg(dqpi_pkg::REG_PROP_GAIN, 32'd32768);
		write_reg(dqpi_pkg::REG_INTEGRAL_GAIN, 32'd4096);
		write_reg(dqpi_pkg::REG_SAT_VOLTAGE_SQ, 32'(100 * AMP));
		write_reg(dqpi_pkg::REG_MAX_CURRENT, 32'(30 * AMP));
		write_reg(dqpi_pkg::REG_SAT_TIME_LIMIT, 32'hFFFF_FFFF);
		write_reg(dqpi_pkg::REG_TICK_PERIOD, 32'h8000_0000);
		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, $urandom);

		add_tick(1'b0, 7 * AMP, -3 * AMP, I_MIN, I_MAX, V_MAX, 1'b0);   // disabled: state holds
		add_tick(1'b1, '0, '0, '0, '0, '0, 1'b0);
		// sustained saturation drives the timer into its upper bound
		repeat (3) add_tick(1'b1, 20 * AMP, -20 * AMP, '0, '0, BUS_48V, 1'b0);
		add_tick(1'b1, 100 * AMP, -100 * AMP, '0, '0, BUS_48V, 1'b0);    // command clamp
		add_tick(1'b1, I_MAX, I_MIN, I_MIN, I_MAX, V_MAX, 1'b0);        // error saturates
		add_tick(1'b1, I_MAX, I_MIN, I_MIN, I_MAX, '0, 1'b0);           // zero bus voltage
		add_tick(1'b0, I_MIN, I_MAX, I_MAX, I_MIN, '0, 1'b0);
		add_tick(1'b1, 5 * AMP, -5 * AMP, 5 * AMP, -5 * AMP, BUS_48V, 1'b0);
		// small outputs run the timer down to zero and hold it there
		repeat (3) add_tick(1'b1, '0, '0, AMP, -AMP, BUS_48V, 1'b0);
		add_tick(1'b1, '0, '0, 40 * AMP, -40 * AMP, BUS_48V, 1'b0);     // negative d error
		add_tick(1'b1, 30 * AMP, -30 * AMP, '0, '0, BUS_48V, 1'b0);     // exactly at clamp
		add_tick(1'b1, 31 * AMP, -31 * AMP, '0, '0, BUS_48V, 1'b1);
		add_tick(1'b1, I_MAX, I_MAX, I_MAX, I_MAX, V_MAX, 1'b0);
		add_tick(1'b1, '0, '0, I_MIN, I_MIN, BUS_48V, 1'b0);
		add_tick(1'b1, 32'sd1, -32'sd1, '0, '0, 31'd1, 1'b0);
		settle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0) begin
				// everything at its low end, fault threshold out of reach
				write_reg(dqpi_pkg::REG_PROP_GAIN, '0);
				write_reg(dqpi_pkg::REG_INTEGRAL_GAIN, '0);
				write_reg(dqpi_pkg::REG_SAT_VOLTAGE_SQ, '0);
				write_reg(dqpi_pkg::REG_MAX_CURRENT, '0);
				write_reg(dqpi_pkg::REG_SAT_TIME_LIMIT, 32'hFFFF_FFFF);
				write_reg(dqpi_pkg::REG_TICK_PERIOD, '0);
			end else if (ph == RAND_PHASES - 1) begin
				// full gains, zero thresholds: fault latches at once
				write_reg(dqpi_pkg::REG_PROP_GAIN, 32'hFFFF_FFFF);
				write_reg(dqpi_pkg::REG_INTEGRAL_GAIN, 32'h7FFF_FFFF);
				write_reg(dqpi_pkg::REG_SAT_VOLTAGE_SQ, '0);
				write_reg(dqpi_pkg::REG_MAX_CURRENT, 32'h7FFF_FFFF);
				write_reg(dqpi_pkg::REG_SAT_TIME_LIMIT, '0);
				write_reg(dqpi_pkg::REG_TICK_PERIOD, 32'hFFFF_FFFF);
			end else begin
				write_reg(dqpi_pkg::REG_PROP_GAIN, pick_reg_value(32'd98304, 32'h7FFF_FFFF));
				write_reg(dqpi_pkg::REG_INTEGRAL_GAIN, pick_reg_value(32'd8192, 32'h7FFF_FFFF));
				write_reg(dqpi_pkg::REG_SAT_VOLTAGE_SQ,
					pick_reg_value(32'(2000 * AMP), 32'h7FFF_FFFF));
				write_reg(dqpi_pkg::REG_MAX_CURRENT,
					pick_reg_value(32'(100 * AMP), 32'h7FFF_FFFF));
				// keep the sticky fault clear until the late phases
				write_reg(dqpi_pkg::REG_SAT_TIME_LIMIT, (ph >= RAND_PHASES - 2)
					? pick_reg_value(32'd20 << 16, 32'hFFFF_FFFF) : 32'hFFFF_FFFF);
				write_reg(dqpi_pkg::REG_TICK_PERIOD,
					pick_reg_value(32'd4 << 16, 32'hFFFF_FFFF));
			end

			set_d = rand_amps(60);
			set_q = rand_amps(60);
			n_en  = 0;
			while (n_en < TICKS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				en   = ($urandom_range(0, 9) != 0);
				if (roll < 80) begin
					// held setpoint with noisy feedback: integrators wind up and clip
					if ($urandom_range(0, 9) == 0) begin
						set_d = rand_amps(60);
						set_q = rand_amps(60);
					end
					dc   = set_d;
					qc   = set_q;
					dm   = dc + rand_amps(8);
					qm   = qc + rand_amps(8);
					vbus = 31'($urandom_range(0, 100 * AMP));
				end else if (roll < 95) begin
					dc   = $urandom;
					qc   = $urandom;
					dm   = $urandom;
					qm   = $urandom;
					vbus = 31'($urandom);
				end else begin
					dc   = corner_val();
					qc   = corner_val();
					dm   = corner_val();
					qm   = corner_val();
					vbus = $urandom_range(0, 1) ? V_MAX : '0;
				end
				add_tick(en, dc, qc, dm, qm, vbus,
					n_en == TICKS_PER_PHASE / 2 || $urandom_range(0, 49) == 0);
				if (en) n_en++;
			end
			settle();
		end

		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
